/* src/world_point_to_pixel_projection_macros.svh */
// ----------------------------------------------------------------------------
// World point to pixel projection: assertion macros
// Short forms for the concurrent checks used by the port checker.
// ----------------------------------------------------------------------------
`ifndef WORLD_POINT_TO_PIXEL_PROJECTION_MACROS_SVH
`define WORLD_POINT_TO_PIXEL_PROJECTION_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WPP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define WPP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Plain check that also holds during reset.
`define WPP_ASSERT_ALWAYS(label, clk, expr, msg) \
    label: assert property (@(posedge clk) (expr)) else $error(msg);

`endif

/* src/wpp_pkg.sv */
// ----------------------------------------------------------------------------
// World point to pixel projection: package
// Widths, register indexes, pipeline stage numbering and shared types.
// ----------------------------------------------------------------------------
package wpp_pkg;

    localparam int COORD_W         = 32;
    localparam int COEF_W          = 32;
    localparam int COORD_FRAC_BITS = 16;
    localparam int PROD_W          = COORD_W + COEF_W;
    localparam int PSUM_W          = PROD_W + 1;
    localparam int SUM_W           = PROD_W + 2;
    localparam int MAG_W           = PROD_W;
    localparam int PIX_W           = 24;
    localparam int DIM_W           = 16;
    localparam int CFG_W           = 64;
    localparam int CFG_IDX_W       = 3;
    localparam int NUM_ROWS        = 3;
    localparam int NUM_MREGS       = 6;

    // Quotient bits resolved by the divider; anything larger saturates.
    localparam int DIV_STEPS = PIX_W;
    localparam int DIV_EXT_W = MAG_W + DIV_STEPS;

    localparam logic [PIX_W-1:0] PIX_MAX = {1'b0, {(PIX_W-1){1'b1}}};
    localparam logic [PIX_W-1:0] PIX_MIN = {1'b1, {(PIX_W-1){1'b0}}};

    localparam logic [DIM_W-1:0] WIDTH_RESET  = 16'd4608;
    localparam logic [DIM_W-1:0] HEIGHT_RESET = 16'd3456;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_ROW0_C01 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW0_C23 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW1_C01 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROW1_C23 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ROW2_C01 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ROW2_C23 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 3'd7;

    // Pipeline stage numbers.
    localparam int ST_MUL     = 0;
    localparam int ST_PSUM    = 1;
    localparam int ST_SUM     = 2;
    localparam int ST_MAG     = 3;
    localparam int ST_OVF     = 4;
    localparam int ST_RND     = ST_OVF + DIV_STEPS + 1;
    localparam int ST_OUT     = ST_RND + 1;
    localparam int NUM_STAGES = ST_OUT + 1;

    typedef struct packed {
        logic [MAG_W-1:0] rem;
        logic [PIX_W-1:0] quo;
        logic             neg;
        logic             ovf;
    } div_lane_t;

    typedef struct packed {
        div_lane_t [1:0]  lane;
        logic [MAG_W-1:0] den;
        logic             dz;
    } div_stage_t;

    typedef struct packed {
        logic [PIX_W-1:0] col;
        logic [PIX_W-1:0] row;
        logic             dz;
    } pix_stage_t;

    // Picks one signed coefficient out of a packed register pair.
    function automatic logic signed [COEF_W-1:0] coef_sel(input logic [CFG_W-1:0] word,
                                                         input logic hi);
        logic signed [COEF_W-1:0] res;
        res = hi ? $signed(word[CFG_W-1:COEF_W]) : $signed(word[COEF_W-1:0]);
        return res;
    endfunction

endpackage

/* src/wpp_point_if.sv */
// ----------------------------------------------------------------------------
// World point channel
// Valid/ready channel carrying one world point in signed Q16.16.
// ----------------------------------------------------------------------------
interface wpp_point_if;
    logic                               valid;
    logic                               ready;
    logic signed [wpp_pkg::COORD_W-1:0] world_x;
    logic signed [wpp_pkg::COORD_W-1:0] world_y;
    logic signed [wpp_pkg::COORD_W-1:0] world_z;

    modport source (output valid, output world_x, output world_y, output world_z,
                    input ready);
    modport sink   (input valid, input world_x, input world_y, input world_z,
                    output ready);
endinterface

/* src/wpp_pixel_if.sv */
// ----------------------------------------------------------------------------
// Pixel channel
// Valid/ready channel carrying one projected pixel and its flags.
// ----------------------------------------------------------------------------
interface wpp_pixel_if;
    logic                             valid;
    logic                             ready;
    logic signed [wpp_pkg::PIX_W-1:0] pixel_col;
    logic signed [wpp_pkg::PIX_W-1:0] pixel_row;
    logic                             inside_image;
    logic                             divisor_zero;

    modport source (output valid, output pixel_col, output pixel_row,
                    output inside_image, output divisor_zero, input ready);
    modport sink   (input valid, input pixel_col, input pixel_row,
                    input inside_image, input divisor_zero, output ready);
endinterface

/* src/world_point_to_pixel_projection.sv */
// ----------------------------------------------------------------------------
// World point to pixel projection
// Pinhole projection of a world point through a configured 3x4 camera matrix.
// ----------------------------------------------------------------------------
// Usage: world points arrive on the point channel as requests of three signed
// Q16.16 coordinates. Each one leaves as one request on the pixel channel: the
// column and row of the projected pixel, rounded half away from zero and
// saturated to 24 bits, a flag telling whether it falls inside the image, and
// a flag for a zero third sum (then the pixel is reported as 0, 0, outside).
// The matrix and image size are written through the cfg_* port while the
// block is idle; reset loads a zero matrix and a 4608 x 3456 image.
// Throughput is one point per cycle while the receiver does not stall. The
// pipeline is 31 register stages deep; the depth is set by the 24 one-bit
// steps of the restoring divider plus the multiply, two add, magnitude,
// overflow, rounding and bounds stages.
// Reset empties the pipeline and clears every valid bit. When the receiver
// stalls, the last result is caught in a one-entry skid register and the whole
// pipeline holds until it drains; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module world_point_to_pixel_projection (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [wpp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [wpp_pkg::CFG_W-1:0]         cfg_data,
    wpp_point_if.sink                         point,
    wpp_pixel_if.source                       pixel
);

    // Configuration registers.
    logic [wpp_pkg::CFG_W-1:0] matrix_reg [wpp_pkg::NUM_MREGS];
    logic [wpp_pkg::DIM_W-1:0] width_reg;
    logic [wpp_pkg::DIM_W-1:0] height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < wpp_pkg::NUM_MREGS; i++)
            begin
                matrix_reg[i] <= '0;
            end
            width_reg  <= wpp_pkg::WIDTH_RESET;
            height_reg <= wpp_pkg::HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                wpp_pkg::REG_WIDTH:  width_reg  <= cfg_data[wpp_pkg::DIM_W-1:0];
                wpp_pkg::REG_HEIGHT: height_reg <= cfg_data[wpp_pkg::DIM_W-1:0];
                default:             matrix_reg[cfg_index] <= cfg_data;
            endcase
        end
    end

    // Pipeline control: every stage moves together unless the skid is full.
    logic                           adv;
    logic [wpp_pkg::NUM_STAGES-1:0] v_reg;
    logic                           skid_v_reg;
    wpp_pkg::pix_stage_t            skid_reg;
    logic                           skid_inside_reg;

    assign adv         = !skid_v_reg;
    assign point.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[wpp_pkg::NUM_STAGES-2:0], point.valid};
        end
    end

    // Stage 0: nine 32x32 products.
    logic signed [wpp_pkg::PROD_W-1:0] prod_reg [wpp_pkg::NUM_ROWS][3];

    for (genvar r = 0; r < wpp_pkg::NUM_ROWS; r++)
    begin : g_mul
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                prod_reg[r][0] <= wpp_pkg::coef_sel(matrix_reg[2*r], 1'b0) * point.world_x;
                prod_reg[r][1] <= wpp_pkg::coef_sel(matrix_reg[2*r], 1'b1) * point.world_y;
                prod_reg[r][2] <= wpp_pkg::coef_sel(matrix_reg[2*r+1], 1'b0) * point.world_z;
            end
        end
    end

    // Stage 1: pairwise sums; the translation column enters as coef * 1.0.
    logic signed [wpp_pkg::PSUM_W-1:0] psum_a_reg [wpp_pkg::NUM_ROWS];
    logic signed [wpp_pkg::PSUM_W-1:0] psum_b_reg [wpp_pkg::NUM_ROWS];
    // Stage 2: full row sums.
    logic signed [wpp_pkg::SUM_W-1:0]  sum_reg [wpp_pkg::NUM_ROWS];
    // Stage 3: sign and magnitude of each sum.
    logic [wpp_pkg::MAG_W-1:0]         mag_reg [wpp_pkg::NUM_ROWS];
    logic [wpp_pkg::NUM_ROWS-1:0]      neg_reg;

    for (genvar r = 0; r < wpp_pkg::NUM_ROWS; r++)
    begin : g_sum
        logic signed [wpp_pkg::PROD_W-1:0] trans;
        logic signed [wpp_pkg::SUM_W-1:0]  abs_sum;

        assign trans = wpp_pkg::PROD_W'(wpp_pkg::coef_sel(matrix_reg[2*r+1], 1'b1))
                       <<< wpp_pkg::COORD_FRAC_BITS;
        assign abs_sum = sum_reg[r][wpp_pkg::SUM_W-1] ? -sum_reg[r] : sum_reg[r];

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                psum_a_reg[r] <= wpp_pkg::PSUM_W'(prod_reg[r][0])
                                 + wpp_pkg::PSUM_W'(prod_reg[r][1]);
                psum_b_reg[r] <= wpp_pkg::PSUM_W'(prod_reg[r][2])
                                 + wpp_pkg::PSUM_W'(trans);
                sum_reg[r]    <= wpp_pkg::SUM_W'(psum_a_reg[r])
                                 + wpp_pkg::SUM_W'(psum_b_reg[r]);
                mag_reg[r]    <= abs_sum[wpp_pkg::MAG_W-1:0];
                neg_reg[r]    <= sum_reg[r][wpp_pkg::SUM_W-1];
            end
        end
    end

    // Stage 4: overflow test (quotient needs more than 24 bits) and divider setup.
    wpp_pkg::div_stage_t div_reg [wpp_pkg::DIV_STEPS+1];
    wpp_pkg::div_stage_t div_init;
    logic [wpp_pkg::DIV_EXT_W-1:0] den_top;

    always_comb
    begin
        den_top       = {mag_reg[2], {wpp_pkg::DIV_STEPS{1'b0}}};
        div_init.den  = mag_reg[2];
        div_init.dz   = (mag_reg[2] == '0);
        for (int l = 0; l < 2; l++)
        begin
            div_init.lane[l].rem = mag_reg[l];
            div_init.lane[l].quo = '0;
            div_init.lane[l].neg = neg_reg[l] ^ neg_reg[2];
            div_init.lane[l].ovf = (wpp_pkg::DIV_EXT_W'(mag_reg[l]) >= den_top);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            div_reg[0] <= div_init;
        end
    end

    // Stages 5 to 28: one quotient bit per stage, most significant first.
    for (genvar g = 0; g < wpp_pkg::DIV_STEPS; g++)
    begin : g_div
        localparam int BIT = wpp_pkg::DIV_STEPS - 1 - g;
        wpp_pkg::div_stage_t step_next;
        logic [wpp_pkg::DIV_EXT_W-1:0] den_sh;

        assign den_sh = wpp_pkg::DIV_EXT_W'(div_reg[g].den) << BIT;

        always_comb
        begin
            step_next = div_reg[g];
            for (int l = 0; l < 2; l++)
            begin
                if (wpp_pkg::DIV_EXT_W'(div_reg[g].lane[l].rem) >= den_sh)
                begin
                    step_next.lane[l].rem = wpp_pkg::MAG_W'(
                        wpp_pkg::DIV_EXT_W'(div_reg[g].lane[l].rem) - den_sh);
                    step_next.lane[l].quo[BIT] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                div_reg[g+1] <= step_next;
            end
        end
    end

    // Stage 29: round half away from zero, apply sign, saturate.
    wpp_pkg::div_stage_t  div_last;
    wpp_pkg::pix_stage_t  rnd_next;
    wpp_pkg::pix_stage_t  rnd_reg;
    logic [wpp_pkg::PIX_W-1:0] pix_val [2];

    assign div_last = div_reg[wpp_pkg::DIV_STEPS];

    always_comb
    begin
        logic                    up;
        logic [wpp_pkg::PIX_W:0] qr;
        for (int l = 0; l < 2; l++)
        begin
            up = ({div_last.lane[l].rem, 1'b0} >= {1'b0, div_last.den});
            qr = {1'b0, div_last.lane[l].quo} + (wpp_pkg::PIX_W+1)'(up);
            if (div_last.dz)
            begin
                pix_val[l] = '0;
            end
            else if (div_last.lane[l].neg)
            begin
                if (div_last.lane[l].ovf || qr >= {2'b01, {(wpp_pkg::PIX_W-1){1'b0}}})
                    pix_val[l] = wpp_pkg::PIX_MIN;
                else
                    pix_val[l] = -qr[wpp_pkg::PIX_W-1:0];
            end
            else
            begin
                if (div_last.lane[l].ovf || qr > {1'b0, wpp_pkg::PIX_MAX})
                    pix_val[l] = wpp_pkg::PIX_MAX;
                else
                    pix_val[l] = qr[wpp_pkg::PIX_W-1:0];
            end
        end
        rnd_next.col = pix_val[0];
        rnd_next.row = pix_val[1];
        rnd_next.dz  = div_last.dz;
    end

    // Stage 30: inside-the-image test against the exclusive bounds.
    wpp_pkg::pix_stage_t out_reg;
    logic                inside_reg;
    logic                inside_next;

    assign inside_next = !rnd_reg.dz
                         && !rnd_reg.col[wpp_pkg::PIX_W-1] && !rnd_reg.row[wpp_pkg::PIX_W-1]
                         && (rnd_reg.col < wpp_pkg::PIX_W'(width_reg))
                         && (rnd_reg.row < wpp_pkg::PIX_W'(height_reg));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rnd_reg    <= rnd_next;
            out_reg    <= rnd_reg;
            inside_reg <= inside_next;
        end
    end

    // Skid register: catches the last stage when the receiver stalls.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_v_reg <= 1'b0;
        end
        else if (skid_v_reg)
        begin
            if (pixel.ready)
                skid_v_reg <= 1'b0;
        end
        else if (v_reg[wpp_pkg::ST_OUT] && !pixel.ready)
        begin
            skid_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!skid_v_reg)
        begin
            skid_reg        <= out_reg;
            skid_inside_reg <= inside_reg;
        end
    end

    assign pixel.valid        = skid_v_reg || v_reg[wpp_pkg::ST_OUT];
    assign pixel.pixel_col    = skid_v_reg ? skid_reg.col : out_reg.col;
    assign pixel.pixel_row    = skid_v_reg ? skid_reg.row : out_reg.row;
    assign pixel.inside_image = skid_v_reg ? skid_inside_reg : inside_reg;
    assign pixel.divisor_zero = skid_v_reg ? skid_reg.dz : out_reg.dz;

endmodule

/* src/wpp_checker.sv */
// ----------------------------------------------------------------------------
// World point to pixel projection: port checker
// Checks on the pixel channel as seen at the top-level ports.
// ----------------------------------------------------------------------------
`include "world_point_to_pixel_projection_macros.svh"

module wpp_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic [wpp_pkg::PIX_W-1:0] pixel_col,
    input logic [wpp_pkg::PIX_W-1:0] pixel_row,
    input logic                      inside_image,
    input logic                      divisor_zero
);

    // A zero divisor reports the origin and never lies inside.
    `WPP_ASSERT_IMPL(a_dz_zero, clk, rst_n, out_valid && divisor_zero, pixel_col == '0 && pixel_row == '0 && !inside_image, "zero divisor with nonzero pixel")

    // An inside pixel has nonnegative coordinates.
    `WPP_ASSERT_IMPL(a_inside_pos, clk, rst_n, out_valid && inside_image, !pixel_col[wpp_pkg::PIX_W-1] && !pixel_row[wpp_pkg::PIX_W-1], "inside pixel is negative")

    // A stalled result stays offered.
    `WPP_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped while stalled")

    // Reset empties the output.
    `WPP_ASSERT_ALWAYS(a_rst_idle, clk, rst_n || !out_valid, "result offered during reset")

endmodule

bind world_point_to_pixel_projection wpp_checker u_wpp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (pixel.valid),
    .out_ready    (pixel.ready),
    .pixel_col    (pixel.pixel_col),
    .pixel_row    (pixel.pixel_row),
    .inside_image (pixel.inside_image),
    .divisor_zero (pixel.divisor_zero)
);

/* dv/wpp_tb_channels.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench channel declarations
// The block's own point and pixel interfaces are used directly; this file
// only gathers the shared testbench record type for the top level.
// ----------------------------------------------------------------------------
package wpp_tb_pkg;

    // One expected pixel result.
    typedef struct packed {
        logic [wpp_pkg::PIX_W-1:0] col;
        logic [wpp_pkg::PIX_W-1:0] row;
        logic                      in_image;
        logic                      dz;
    } pixel_expect_t;

endpackage

/* dv/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// World point to pixel projection testbench
// Drives world points through the projection block under several camera
// matrices and image sizes, predicts each pixel with an exact 128-bit model
// and checks every result in order, with random sender gaps and receiver
// stalls.
// ----------------------------------------------------------------------------
module testbench;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [wpp_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [wpp_pkg::CFG_W-1:0] cfg_data;

    wpp_point_if point ();
    wpp_pixel_if pixel ();

    world_point_to_pixel_projection dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .point     (point),
        .pixel     (pixel)
    );

    // The block is pipelined 31 deep; drain waits allow some extra margin.
    localparam int LATENCY     = 31;
    localparam int CYCLE_LIMIT = 400000;

    // Local copy of the configuration, mirrored on every register write.
    logic [wpp_pkg::CFG_W-1:0] matrix_words [wpp_pkg::NUM_MREGS];
    logic [wpp_pkg::DIM_W-1:0] width_cfg;
    logic [wpp_pkg::DIM_W-1:0] height_cfg;

    wpp_tb_pkg::pixel_expect_t pending_pixels [$];
    int mismatches;
    int checked_count;
    int sent_count;
    int cycle_count;
    int dz_count;
    int inside_count;
    int sat_count;
    bit stall_enable;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Global watchdog on the cycle count.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("world_point_to_pixel_projection regression: fail");
            $finish;
        end
    end

    function automatic logic signed [127:0] coef_of(int r, int c);
        logic [wpp_pkg::CFG_W-1:0] word;
        logic signed [31:0] k;
        word = matrix_words[r * 2 + c / 2];
        k = (c % 2 == 1) ? word[63:32] : word[31:0];
        return 128'(k);
    endfunction

    // Half away from zero, then saturate to the 24-bit signed pixel range.
    function automatic logic signed [127:0] divide_round_sat(logic signed [127:0] num,
                                                            logic signed [127:0] den);
        logic [127:0] nm;
        logic [127:0] dm;
        logic [127:0] q;
        logic [127:0] r;
        logic neg;
        nm = num[127] ? -num : num;
        dm = den[127] ? -den : den;
        neg = num[127] ^ den[127];
        q = nm / dm;
        r = nm % dm;
        if (r >= dm - r)
            q = q + 1;
        if (neg)
            return (q >= 128'd8388608) ? -128'sd8388608 : -$signed(q);
        return (q > 128'd8388607) ? 128'sd8388607 : $signed(q);
    endfunction

    function automatic wpp_tb_pkg::pixel_expect_t project_point(logic signed [31:0] wx,
                                                                logic signed [31:0] wy,
                                                                logic signed [31:0] wz);
        wpp_tb_pkg::pixel_expect_t e;
        logic signed [127:0] sums [3];
        logic signed [127:0] pc;
        logic signed [127:0] pr;
        for (int r = 0; r < 3; r++)
            sums[r] = coef_of(r, 0) * 128'(wx) + coef_of(r, 1) * 128'(wy)
                    + coef_of(r, 2) * 128'(wz)
                    + coef_of(r, 3) * (128'sd1 << wpp_pkg::COORD_FRAC_BITS);
        e = '0;
        if (sums[2] == 0)
            e.dz = 1'b1;
        else
        begin
            pc = divide_round_sat(sums[0], sums[2]);
            pr = divide_round_sat(sums[1], sums[2]);
            e.col = pc[wpp_pkg::PIX_W-1:0];
            e.row = pr[wpp_pkg::PIX_W-1:0];
            e.in_image = (pc >= 0) && (pr >= 0) && (pc < 128'(width_cfg))
                      && (pr < 128'(height_cfg));
        end
        return e;
    endfunction

    // Register writes happen only while the pipeline is empty.
    task automatic write_reg(logic [wpp_pkg::CFG_IDX_W-1:0] idx,
                             logic [wpp_pkg::CFG_W-1:0] value);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx < wpp_pkg::NUM_MREGS)
            matrix_words[idx] = value;
        else if (idx == wpp_pkg::REG_WIDTH)
            width_cfg = value[wpp_pkg::DIM_W-1:0];
        else if (idx == wpp_pkg::REG_HEIGHT)
            height_cfg = value[wpp_pkg::DIM_W-1:0];
    endtask

    task automatic load_camera(logic signed [31:0] k [12], int w, int h);
        write_reg(wpp_pkg::REG_ROW0_C01, {k[1], k[0]});
        write_reg(wpp_pkg::REG_ROW0_C23, {k[3], k[2]});
        write_reg(wpp_pkg::REG_ROW1_C01, {k[5], k[4]});
        write_reg(wpp_pkg::REG_ROW1_C23, {k[7], k[6]});
        write_reg(wpp_pkg::REG_ROW2_C01, {k[9], k[8]});
        write_reg(wpp_pkg::REG_ROW2_C23, {k[11], k[10]});
        write_reg(wpp_pkg::REG_WIDTH, 64'(w));
        write_reg(wpp_pkg::REG_HEIGHT, 64'(h));
    endtask

    // Sends one request; the expectation is queued at the accepting edge.
    task automatic send_point(logic signed [31:0] wx, logic signed [31:0] wy,
                              logic signed [31:0] wz);
        point.valid = 1'b1;
        point.world_x = wx;
        point.world_y = wy;
        point.world_z = wz;
        do
            @(posedge clk);
        while (!point.ready);
        pending_pixels.push_back(project_point(wx, wy, wz));
        sent_count++;
        @(negedge clk);
        point.valid = 1'b0;
    endtask

    // Bursty sender: random gaps between bursts, no gap inside a burst.
    int burst_left;
    task automatic send_paced(logic signed [31:0] wx, logic signed [31:0] wy,
                              logic signed [31:0] wz);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            repeat ($urandom_range(0, 6)) @(negedge clk);
        end
        burst_left--;
        point.valid = 1'b1;
        point.world_x = wx;
        point.world_y = wy;
        point.world_z = wz;
        do
            @(posedge clk);
        while (!point.ready);
        pending_pixels.push_back(project_point(wx, wy, wz));
        sent_count++;
        @(negedge clk);
        if (burst_left == 0)
            point.valid = 1'b0;
    endtask

    task automatic drain_results();
        point.valid = 1'b0;
        while (pending_pixels.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    // Receiver stall pattern: alternating stall-free and stall-heavy stretches.
    always @(negedge clk)
    begin
        if (!stall_enable)
            pixel.ready <= 1'b1;
        else if (cycle_count % 512 < 128)
            pixel.ready <= 1'b1;
        else
            pixel.ready <= ($urandom_range(0, 99) < 65);
    end

    // Result checker: compares each accepted result with the oldest prediction.
    always @(posedge clk)
    begin
        wpp_tb_pkg::pixel_expect_t want;
        if (rst_n && pixel.valid && pixel.ready)
        begin
            if (pending_pixels.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected pixel col=%0d row=%0d", $signed(pixel.pixel_col),
                             $signed(pixel.pixel_row));
            end
            else
            begin
                want = pending_pixels.pop_front();
                checked_count++;
                dz_count += want.dz;
                inside_count += want.in_image;
                if (!want.dz && ((want.col == wpp_pkg::PIX_MAX)
                                 || (want.col == wpp_pkg::PIX_MIN)))
                    sat_count++;
                if (pixel.pixel_col !== want.col || pixel.pixel_row !== want.row
                    || pixel.inside_image !== want.in_image
                    || pixel.divisor_zero !== want.dz)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"pixel %0d mismatch: exp col=%0d row=%0d in=%0b dz=%0b,",
                                  " got col=%0d row=%0d in=%0b dz=%0b"},
                                 checked_count, $signed(want.col), $signed(want.row),
                                 want.in_image, want.dz, $signed(pixel.pixel_col),
                                 $signed(pixel.pixel_row), pixel.inside_image,
                                 pixel.divisor_zero);
                end
            end
        end
    end

    // A simple camera: focal length f / 65536 and principal point (cx, cy) / 65536, looking down +z.
    task automatic load_pinhole(int f, int cx, int cy, int w, int h);
        logic signed [31:0] k [12];
        k = '{default: 32'sd0};
        k[0] = f <<< 8;
        k[2] = cx <<< 8;
        k[5] = f <<< 8;
        k[6] = cy <<< 8;
        k[10] = 32'sd1 <<< 24;
        load_camera(k, w, h);
    endtask

    function automatic logic signed [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return $signed(32'($urandom_range(0, 8)) - 32'sd4);
            default: return $signed($urandom());
        endcase
    endfunction

    task automatic test_reset_matrix();
        // A zero matrix gives a zero divisor for every point.
        send_point(32'sd0, 32'sd0, 32'sd0);
        send_point(32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff);
        drain_results();
    endtask

    task automatic test_directed_pinhole();
        load_pinhole(1000, 2304, 1728, 4608, 3456);
        send_point(32'sd0, 32'sd0, 32'sd65536);
        send_point(32'sd65536, -32'sd65536, 32'sd131072);
        send_point(32'sh8000_0000, 32'sh8000_0000, 32'sd1);
        send_point(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sd1);
        send_point(32'sh7fff_ffff, 32'sh8000_0000, -32'sd1);
        send_point(32'sd1, 32'sd1, 32'sd0);
        send_point(32'sd0, 32'sd0, -32'sd65536);
        send_point(32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000);
        send_point(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff);
        drain_results();
    endtask

    task automatic test_rounding_and_bounds();
        logic signed [31:0] k [12];
        // Identity-like matrix: col = x / z, row = y / z, exposing half-way ties.
        k = '{default: 32'sd0};
        k[0] = 32'sd1 <<< 24;
        k[5] = 32'sd1 <<< 24;
        k[10] = 32'sd1 <<< 24;
        load_camera(k, 1, 1);
        send_point(32'sd3, 32'sd1, 32'sd2);
        send_point(-32'sd3, -32'sd1, 32'sd2);
        send_point(32'sd5, 32'sd4, -32'sd2);
        send_point(32'sd0, 32'sd0, 32'sd7);
        send_point(32'sd1, 32'sd0, 32'sd1);
        send_point(32'sd0, 32'sd1, 32'sd1);
        drain_results();
        // Largest image; the exclusive bound at 65535 and the translation column.
        k[3] = 32'sh7fff_ffff;
        k[7] = 32'sh8000_0000;
        k[11] = 32'sd1;
        load_camera(k, 65535, 65535);
        send_point(32'sd65534, 32'sd65535, 32'sd1);
        send_point(32'sd0, 32'sd0, 32'sd0);
        send_point(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000);
        drain_results();
        // Zero image size: written value 0 leaves nothing inside.
        load_camera(k, 0, 0);
        send_point(32'sd0, 32'sd0, 32'sd1);
        drain_results();
    endtask

    // Random matrices across several phases, mostly realistic cameras.
    task automatic test_random_projection(int phases, int per_phase);
        logic signed [31:0] k [12];
        for (int p = 0; p < phases; p++)
        begin
            if (p % 3 == 2)
            begin
                for (int i = 0; i < 12; i++)
                    k[i] = rand_word();
                load_camera(k, $urandom_range(0, 65535), $urandom_range(0, 65535));
            end
            else
                load_pinhole($urandom_range(100, 30000), $urandom_range(0, 65535),
                             $urandom_range(0, 65535), $urandom_range(1, 65535),
                             $urandom_range(1, 65535));
            for (int n = 0; n < per_phase; n++)
            begin
                if (p % 3 == 2 || $urandom_range(0, 9) == 0)
                    send_paced(rand_word(), rand_word(), rand_word());
                else
                    send_paced($signed($urandom_range(0, 32'h3fff_ffff)) - 32'sh2000_0000,
                               $signed($urandom_range(0, 32'h3fff_ffff)) - 32'sh2000_0000,
                               $signed($urandom_range(1, 32'h00ff_ffff)));
                // Pause once mid-phase until the pipeline has fully drained.
                if (n == per_phase / 2 && p == 1)
                begin
                    point.valid = 1'b0;
                    burst_left = 0;
                    while (pending_pixels.size() != 0)
                        @(negedge clk);
                end
            end
            drain_results();
            burst_left = 0;
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        point.valid = 1'b0;
        point.world_x = '0;
        point.world_y = '0;
        point.world_z = '0;
        pixel.ready = 1'b1;
        stall_enable = 1'b0;
        mismatches = 0;
        checked_count = 0;
        sent_count = 0;
        cycle_count = 0;
        dz_count = 0;
        inside_count = 0;
        sat_count = 0;
        burst_left = 0;
        for (int i = 0; i < wpp_pkg::NUM_MREGS; i++)
            matrix_words[i] = '0;
        width_cfg = wpp_pkg::WIDTH_RESET;
        height_cfg = wpp_pkg::HEIGHT_RESET;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_matrix();
        test_directed_pinhole();
        stall_enable = 1'b1;
        test_rounding_and_bounds();
        test_random_projection(10, 150);
        drain_results();

        $display("sent %0d points, checked %0d pixels", sent_count, checked_count);
        $display("zero divisors %0d, inside image %0d, saturated columns %0d",
                 dz_count, inside_count, sat_count);
        if (mismatches == 0 && pending_pixels.size() == 0)
            $display("world_point_to_pixel_projection regression: pass");
        else
            $display("world_point_to_pixel_projection regression: fail");
        $finish;
    end
endmodule

/* files.f */
+incdir+src
src/wpp_pkg.sv
src/wpp_point_if.sv
src/wpp_pixel_if.sv
src/world_point_to_pixel_projection.sv
src/wpp_checker.sv
dv/wpp_tb_channels.sv
dv/testbench.sv
